// ===== sv/amgd_pkg.sv =====
package amgd_pkg;

	// Graph size and field widths
	localparam int MAX_V   = 16;
	localparam int VIDX_W  = $clog2(MAX_V);
	localparam int CNT_W   = $clog2(MAX_V + 1);
	localparam int LABEL_W = 32;

	// Action codes carried by the action field
	typedef enum logic [2:0] {
		ACT_ADD_VERTEX  = 3'd0,
		ACT_ADD_EDGE    = 3'd1,
		ACT_DEL_EDGE    = 3'd2,
		ACT_QUERY_EDGE  = 3'd3,
		ACT_NEIGHBORS   = 3'd4,
		ACT_DFS         = 3'd5,
		ACT_READ_LABEL  = 3'd6,
		ACT_WRITE_LABEL = 3'd7
	} amgd_action_t;

	// Result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_ERR   = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_ONE,
		ST_FIRST,
		ST_TOP,
		ST_ROWRD,
		ST_LOADSC,
		ST_SCAN,
		ST_PUT,
		ST_FIN
	} amgd_state_t;

	// Controls into the row scanner
	typedef struct packed {
		logic load;
		logic resume;
	} scan_ctl_t;

	// Status out of the row scanner
	typedef struct packed {
		logic              active;
		logic              hit;
		logic [VIDX_W-1:0] idx;
	} scan_stat_t;

endpackage

// ===== sv/amgd_scan.sv =====
module amgd_scan (
	input  logic                             clk,
	input  logic                             arst_n,
	input  amgd_pkg::scan_ctl_t              ctl,
	input  logic [amgd_pkg::MAX_V-1:0]       row,
	output amgd_pkg::scan_stat_t             stat
);
	import amgd_pkg::*;

	logic [MAX_V-1:0]  row_q;
	logic [VIDX_W-1:0] idx_q;
	logic              active_q;
	logic              hit;

	// Check one bit of the loaded row per cycle, unless held on a hit
	assign hit = active_q & row_q[idx_q];

	// Capture the candidate row
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			row_q <= row;
		end
	end

	// Advance the bit pointer; hold on a hit until resumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (ctl.load) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (active_q && (!hit || ctl.resume)) begin
			if (idx_q == VIDX_W'(MAX_V - 1)) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q + VIDX_W'(1);
			end
		end
	end

	assign stat = '{active: active_q, hit: hit, idx: idx_q};

endmodule

// ===== sv/adjacency_matrix_graph_dfs.sv =====
// Directed graph of up to 16 vertices held as a bit adjacency matrix, with one
// label per vertex. The input channel (in_valid/in_stall) carries one action per
// transaction; the output channel (out_valid/out_stall) returns one or more
// result transactions per action, the final one marked by last.
// in_stall is high from the cycle after an action is taken until its last
// result has been loaded into the output register; one action runs at a time.
// Single-result actions pass from the read state to the one-result state, which
// loads the result into the output register and frees the input as it does so.
// A neighbor list fetches its row, loads it into the row scanner, scans all 16
// bits and passes each listed vertex through the put state. A depth-first walk
// reads the stack top, fetches that vertex's row and loads the scanner (ST_TOP,
// ST_ROWRD, ST_LOADSC) on every push and every pop, scans the row and stores a
// pushed vertex in ST_PUT. The row scanner checks one adjacency bit per cycle,
// holding on a hit until resumed. A stalled receiver holds the output register;
// the sequencer then waits with the next result in a one-entry holding register.
// Reset clears the vertex count, the walk stack and all handshake state; the
// matrix and label memories are not cleared, since a vertex is written when it
// is added and only vertices below the count are ever read.
module adjacency_matrix_graph_dfs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [3:0]  source,
	input  logic [3:0]  target,
	input  logic [31:0] label_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  vertex_out,
	output logic [31:0] label_out,
	output logic        edge_present,
	output logic [1:0]  status,
	output logic        last
);
	import amgd_pkg::*;

	amgd_state_t state_q, state_d;

	// Item registers
	amgd_action_t      act_q;
	logic [VIDX_W-1:0] src_q, dst_q;
	logic [LABEL_W-1:0] lab_q;
	logic              err_q;

	// Graph state
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] depth_q;
	logic [MAX_V-1:0] visited_q;

	// Memories and their registered read data
	logic [MAX_V-1:0]   edge_mem [MAX_V];
	logic [LABEL_W-1:0] label_mem [MAX_V];
	logic [VIDX_W-1:0]  stack_mem [MAX_V];
	logic [MAX_V-1:0]   edge_rd_q;
	logic [LABEL_W-1:0] label_rd_q;
	logic [VIDX_W-1:0]  stack_rd_q;

	// Pending result, held until it is known whether it is the last
	logic               pend_v_q;
	logic [VIDX_W-1:0]  pend_vertex_q;
	logic [LABEL_W-1:0] pend_label_q;

	// Output register
	logic               out_valid_q;
	logic [VIDX_W-1:0]  out_vertex_q;
	logic [LABEL_W-1:0] out_label_q;
	logic               out_edge_q;
	logic [1:0]         out_status_q;
	logic               out_last_q;

	// Scanner
	scan_ctl_t  scan_ctl;
	scan_stat_t scan_st;

	// Control from the output block
	logic               accept, err_in, dfs_start, out_free;
	logic               out_load;
	logic [VIDX_W-1:0]  res_vertex;
	logic [LABEL_W-1:0] res_label;
	logic               res_edge;
	logic [1:0]         res_status;
	logic               res_last;
	logic               edge_we, label_we, stack_we;
	logic [VIDX_W-1:0]  edge_waddr, label_waddr, stack_waddr;
	logic [MAX_V-1:0]   edge_wdata;
	logic [LABEL_W-1:0] label_wdata;
	logic [VIDX_W-1:0]  stack_wdata;
	logic [VIDX_W-1:0]  edge_raddr, label_raddr, stack_raddr;
	logic               cnt_inc, depth_inc, depth_dec, vis_add;
	logic               pend_load, pend_clr;
	logic [VIDX_W-1:0]  pend_vertex_d;
	logic [MAX_V-1:0]   scan_row;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Range check of the incoming action
	always_comb begin
		unique case (amgd_action_t'(action))
			ACT_ADD_VERTEX: err_in = (count_q == CNT_W'(MAX_V));
			ACT_ADD_EDGE, ACT_DEL_EDGE, ACT_QUERY_EDGE:
				err_in = (CNT_W'(source) >= count_q) || (CNT_W'(target) >= count_q);
			default: err_in = (CNT_W'(source) >= count_q);
		endcase
	end

	assign dfs_start = accept && (amgd_action_t'(action) == ACT_DFS) && !err_in;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_READ;
			end
			ST_READ: begin
				if (err_q) state_d = ST_ONE;
				else if (act_q == ACT_NEIGHBORS) state_d = ST_LOADSC;
				else if (act_q == ACT_DFS) state_d = ST_FIRST;
				else state_d = ST_ONE;
			end
			ST_ONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_FIRST:  state_d = ST_TOP;
			ST_TOP:    state_d = ST_ROWRD;
			ST_ROWRD:  state_d = ST_LOADSC;
			ST_LOADSC: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_st.hit) begin
					state_d = ST_PUT;
				end else if (!scan_st.active) begin
					if (act_q == ACT_NEIGHBORS || depth_q == CNT_W'(1)) state_d = ST_FIN;
					else state_d = ST_TOP;
				end
			end
			ST_PUT: begin
				if (!pend_v_q || out_free) begin
					state_d = (act_q == ACT_NEIGHBORS) ? ST_SCAN : ST_TOP;
				end
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		out_load      = 1'b0;
		res_vertex    = '0;
		res_label     = '0;
		res_edge      = 1'b0;
		res_status    = STAT_OK;
		res_last      = 1'b0;
		edge_we       = 1'b0;
		edge_waddr    = src_q;
		edge_wdata    = edge_rd_q;
		label_we      = 1'b0;
		label_waddr   = src_q;
		label_wdata   = lab_q;
		stack_we      = dfs_start;
		stack_waddr   = '0;
		stack_wdata   = source;
		edge_raddr    = src_q;
		label_raddr   = src_q;
		stack_raddr   = VIDX_W'(depth_q - CNT_W'(1));
		cnt_inc       = 1'b0;
		depth_inc     = 1'b0;
		depth_dec     = 1'b0;
		vis_add       = 1'b0;
		pend_load     = 1'b0;
		pend_clr      = 1'b0;
		pend_vertex_d = src_q;
		scan_ctl      = '{load: 1'b0, resume: 1'b0};
		// Mask visited vertices only for a walk; a neighbor list sees the whole row
		scan_row      = (act_q == ACT_DFS) ? (edge_rd_q & ~visited_q) : edge_rd_q;
		unique case (state_q)
			ST_ONE: begin
				out_load = out_free;
				res_last = 1'b1;
				if (err_q) begin
					res_status = STAT_ERR;
				end else begin
					unique case (act_q)
						ACT_ADD_VERTEX: begin
							res_vertex  = count_q[VIDX_W-1:0];
							res_label   = lab_q;
							edge_we     = out_free;
							edge_waddr  = count_q[VIDX_W-1:0];
							edge_wdata  = '0;
							label_we    = out_free;
							label_waddr = count_q[VIDX_W-1:0];
							cnt_inc     = out_free;
						end
						ACT_ADD_EDGE: begin
							edge_we    = out_free;
							edge_wdata = edge_rd_q | (MAX_V'(1) << dst_q);
						end
						ACT_DEL_EDGE: begin
							edge_we    = out_free;
							edge_wdata = edge_rd_q & ~(MAX_V'(1) << dst_q);
						end
						ACT_QUERY_EDGE: res_edge = edge_rd_q[dst_q];
						ACT_READ_LABEL: begin
							res_vertex = src_q;
							res_label  = label_rd_q;
						end
						ACT_WRITE_LABEL: begin
							res_vertex = src_q;
							res_label  = lab_q;
							label_we   = out_free;
						end
						default: res_status = STAT_OK;
					endcase
				end
			end
			ST_FIRST: begin
				pend_load     = 1'b1;
				pend_vertex_d = src_q;
			end
			ST_ROWRD: begin
				edge_raddr = stack_rd_q;
			end
			ST_LOADSC: begin
				scan_ctl.load = 1'b1;
			end
			ST_SCAN: begin
				label_raddr = scan_st.idx;
				depth_dec   = !scan_st.hit && !scan_st.active && (act_q == ACT_DFS);
			end
			ST_PUT: begin
				label_raddr = scan_st.idx;
				if (!pend_v_q || out_free) begin
					// flush the previous result, then hold the new one
					out_load      = pend_v_q;
					res_vertex    = pend_vertex_q;
					res_label     = pend_label_q;
					pend_load     = 1'b1;
					pend_vertex_d = scan_st.idx;
					if (act_q == ACT_NEIGHBORS) begin
						scan_ctl.resume = 1'b1;
					end else begin
						stack_we    = 1'b1;
						stack_waddr = depth_q[VIDX_W-1:0];
						stack_wdata = scan_st.idx;
						depth_inc   = 1'b1;
						vis_add     = 1'b1;
					end
				end
			end
			ST_FIN: begin
				out_load = out_free;
				res_last = 1'b1;
				pend_clr = out_free;
				if (pend_v_q) begin
					res_vertex = pend_vertex_q;
					res_label  = pend_label_q;
				end else begin
					res_status = STAT_EMPTY;
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			depth_q     <= '0;
			visited_q   <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) count_q <= count_q + CNT_W'(1);
			if (dfs_start) depth_q <= CNT_W'(1);
			else if (depth_inc) depth_q <= depth_q + CNT_W'(1);
			else if (depth_dec) depth_q <= depth_q - CNT_W'(1);
			if (dfs_start) visited_q <= MAX_V'(1) << source;
			else if (vis_add) visited_q <= visited_q | (MAX_V'(1) << scan_st.idx);
			if (pend_clr) pend_v_q <= 1'b0;
			else if (pend_load) pend_v_q <= 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Capture the item, the pending result and the output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= amgd_action_t'(action);
			src_q <= source;
			dst_q <= target;
			lab_q <= label_in;
			err_q <= err_in;
		end
		if (pend_load) begin
			pend_vertex_q <= pend_vertex_d;
			pend_label_q  <= label_rd_q;
		end
		if (out_load) begin
			out_vertex_q <= res_vertex;
			out_label_q  <= res_label;
			out_edge_q   <= res_edge;
			out_status_q <= res_status;
			out_last_q   <= res_last;
		end
	end

	// Adjacency rows
	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
		edge_rd_q <= edge_mem[edge_raddr];
	end

	// Vertex labels
	always_ff @(posedge clk) begin
		if (label_we) label_mem[label_waddr] <= label_wdata;
		label_rd_q <= label_mem[label_raddr];
	end

	// Walk stack
	always_ff @(posedge clk) begin
		if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
		stack_rd_q <= stack_mem[stack_raddr];
	end

	amgd_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.row    (scan_row),
		.stat   (scan_st)
	);

	assign out_valid    = out_valid_q;
	assign vertex_out   = out_vertex_q;
	assign label_out    = out_label_q;
	assign edge_present = out_edge_q;
	assign status       = out_status_q;
	assign last         = out_last_q;

	// A held result only exists while an action is in progress
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q != ST_IDLE))
		else $error("pending result outside an action");

	// The walk stack never grows past the vertex count
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= count_q)
		else $error("walk stack deeper than vertex count");

	// A walk never selects a vertex it has already visited
	a_unvisited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_st.hit && act_q == ACT_DFS) |-> !visited_q[scan_st.idx])
		else $error("walk revisits a vertex");

	// A result loads only when the output register can take it
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> !$changed(out_vertex_q) && !$changed(out_last_q))
		else $error("output register overwritten while stalled");

endmodule

// ===== sim/tb_adjacency_matrix_graph_dfs.sv =====
module tb_adjacency_matrix_graph_dfs;
	import amgd_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int LONG_HOLD    = 400;
	localparam int RESULT_CAP   = 16;
	localparam int RESET_CYCLES = 8;

	typedef struct packed {
		logic [3:0]  vertex;
		logic [31:0] label;
		logic        edge_hit;
		logic [1:0]  status;
		logic        last;
	} graph_result_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_stall;
	amgd_action_t action = ACT_ADD_VERTEX;
	logic [3:0]   source = '0;
	logic [3:0]   target = '0;
	logic [31:0]  label_in = '0;
	logic         out_valid;
	logic         out_stall = 1'b0;
	logic [3:0]   vertex_out;
	logic [31:0]  label_out;
	logic         edge_present;
	logic [1:0]   status;
	logic         last;

	// Shadow graph state
	logic [MAX_V-1:0] graph_rows [MAX_V];
	logic [31:0]      vertex_names [MAX_V];
	int               vertex_total = 0;

	graph_result_t expected_results[$];
	int            mismatch_count = 0;
	int            cycle_count = 0;
	bit            idle_mode = 1'b0;
	bit            long_hold_req = 1'b0;

	adjacency_matrix_graph_dfs i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.source       (source),
		.target       (target),
		.label_in     (label_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex_out   (vertex_out),
		.label_out    (label_out),
		.edge_present (edge_present),
		.status       (status),
		.last         (last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void push_result(logic [3:0] v, logic [31:0] lab, logic hit,
			logic [1:0] st, logic fin);
		graph_result_t r;
		r.vertex   = v;
		r.label    = lab;
		r.edge_hit = hit;
		r.status   = st;
		r.last     = fin;
		expected_results.push_back(r);
	endfunction

	// Flag the newest expected result as the final one of its action
	function automatic void mark_final();
		graph_result_t r;
		r = expected_results.pop_back();
		r.last = 1'b1;
		expected_results.push_back(r);
	endfunction

	// Update the shadow graph for one accepted action and queue its results
	function automatic void predict_graph_action(amgd_action_t act, logic [3:0] src,
			logic [3:0] dst, logic [31:0] lab);
		int               n;
		int               produced;
		int               depth;
		int               nxt;
		bit               found;
		logic [3:0]       top;
		logic [MAX_V-1:0] seen;
		logic [MAX_V-1:0] cand;
		logic [3:0]       trail [MAX_V];
		n = vertex_total;
		produced = 0;
		case (act)
			ACT_ADD_VERTEX: begin
				if (n >= MAX_V) begin
					push_result('0, '0, 1'b0, STAT_ERR, 1'b1);
				end else begin
					for (int i = 0; i < n; i++)
						graph_rows[i][n] = 1'b0;
					graph_rows[n] = '0;
					vertex_names[n] = lab;
					vertex_total = n + 1;
					push_result(4'(n), lab, 1'b0, STAT_OK, 1'b1);
				end
			end
			ACT_ADD_EDGE, ACT_DEL_EDGE, ACT_QUERY_EDGE: begin
				if (src >= n || dst >= n) begin
					push_result('0, '0, 1'b0, STAT_ERR, 1'b1);
				end else if (act == ACT_ADD_EDGE) begin
					graph_rows[src][dst] = 1'b1;
					push_result('0, '0, 1'b0, STAT_OK, 1'b1);
				end else if (act == ACT_DEL_EDGE) begin
					graph_rows[src][dst] = 1'b0;
					push_result('0, '0, 1'b0, STAT_OK, 1'b1);
				end else begin
					push_result('0, '0, graph_rows[src][dst], STAT_OK, 1'b1);
				end
			end
			default: begin
				if (src >= n) begin
					push_result('0, '0, 1'b0, STAT_ERR, 1'b1);
				end else if (act == ACT_NEIGHBORS) begin
					for (int i = 0; i < n && produced < RESULT_CAP; i++) begin
						if (graph_rows[src][i]) begin
							push_result(4'(i), vertex_names[i], 1'b0, STAT_OK, 1'b0);
							produced++;
						end
					end
					if (produced == 0)
						push_result('0, '0, 1'b0, STAT_EMPTY, 1'b1);
					else
						mark_final();
				end else if (act == ACT_DFS) begin
					// Preorder walk with an explicit stack, lowest neighbor first
					seen = '0;
					seen[src] = 1'b1;
					trail[0] = src;
					depth = 1;
					push_result(src, vertex_names[src], 1'b0, STAT_OK, 1'b0);
					produced = 1;
					while (depth > 0 && produced < RESULT_CAP) begin
						top = trail[depth-1];
						cand = graph_rows[top] & ~seen;
						found = 1'b0;
						nxt = 0;
						for (int i = 0; i < n; i++) begin
							if (!found && cand[i]) begin
								found = 1'b1;
								nxt = i;
							end
						end
						if (found && depth < MAX_V) begin
							seen[nxt] = 1'b1;
							trail[depth] = 4'(nxt);
							depth++;
							push_result(4'(nxt), vertex_names[nxt], 1'b0, STAT_OK, 1'b0);
							produced++;
						end else begin
							depth--;
						end
					end
					mark_final();
				end else if (act == ACT_READ_LABEL) begin
					push_result(src, vertex_names[src], 1'b0, STAT_OK, 1'b1);
				end else begin
					vertex_names[src] = lab;
					push_result(src, lab, 1'b0, STAT_OK, 1'b1);
				end
			end
		endcase
	endfunction

	// Offer one action and hold it until the block takes the transaction
	task automatic send_action(amgd_action_t act, logic [3:0] src, logic [3:0] dst,
			logic [31:0] lab);
		int gap;
		if (idle_mode && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		source   <= src;
		target   <= dst;
		label_in <= lab;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_graph_action(act, src, dst, lab);
	endtask

	// Pick a random action, mostly on vertices that exist
	task automatic send_random();
		amgd_action_t act;
		logic [3:0]   s;
		logic [3:0]   d;
		act = amgd_action_t'($urandom_range(0, 7));
		s = 4'($urandom_range(0, 15));
		d = 4'($urandom_range(0, 15));
		if (vertex_total > 0 && $urandom_range(0, 4) != 0) begin
			s = 4'($urandom_range(0, vertex_total - 1));
			d = 4'($urandom_range(0, vertex_total - 1));
		end
		send_action(act, s, d, $urandom());
	endtask

	// Stop offering and wait until every expected result has arrived
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0 || in_stall) @(posedge clk);
	endtask

	// Drive receiver stalls: random bursts, or one long hold on request
	initial begin : receiver
		int hold_cycles;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				hold_cycles = 0;
				while (hold_cycles < LONG_HOLD) begin
					@(posedge clk);
					hold_cycles++;
				end
				out_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else if (idle_mode && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic note_mismatch(string what, graph_result_t want, graph_result_t got);
		if (mismatch_count < 10) begin
			$display("MISMATCH %s: expected v=%0d lab=%h edge=%b st=%0d last=%b",
				what, want.vertex, want.label, want.edge_hit, want.status, want.last);
			$display("    actual v=%0d lab=%h edge=%b st=%0d last=%b",
				got.vertex, got.label, got.edge_hit, got.status, got.last);
		end
		mismatch_count++;
	endtask

	// Compare each accepted result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		graph_result_t want;
		graph_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.vertex   = vertex_out;
			got.label    = label_out;
			got.edge_hit = edge_present;
			got.status   = status;
			got.last     = last;
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected", '0, got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want)
					note_mismatch("result", want, got);
			end
		end
	end

	// Every action but adding a vertex is out of range on an empty graph
	task automatic test_empty_graph();
		send_action(ACT_ADD_EDGE, 4'd0, 4'd0, '0);
		send_action(ACT_DEL_EDGE, 4'd0, 4'd1, '0);
		send_action(ACT_QUERY_EDGE, 4'd1, 4'd0, '0);
		send_action(ACT_NEIGHBORS, 4'd0, 4'd0, '0);
		send_action(ACT_DFS, 4'd0, 4'd0, '0);
		send_action(ACT_READ_LABEL, 4'd0, 4'd0, '0);
		send_action(ACT_WRITE_LABEL, 4'd3, 4'd0, 32'h1234_5678);
		send_action(ACT_DFS, 4'd15, 4'd0, '0);
		drain_results();
	endtask

	// Add vertices with random labels
	task automatic test_add_vertices();
		for (int i = 0; i < 10; i++)
			send_action(ACT_ADD_VERTEX, 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)), $urandom());
		drain_results();
	endtask

	// Add, remove and query edges, some out of range
	task automatic test_edges();
		amgd_action_t act;
		for (int i = 0; i < 40; i++) begin
			case ($urandom_range(0, 3))
				0: act = ACT_DEL_EDGE;
				1: act = ACT_QUERY_EDGE;
				default: act = ACT_ADD_EDGE;
			endcase
			send_action(act, 4'($urandom_range(0, 11)), 4'($urandom_range(0, 11)), '0);
		end
		drain_results();
	endtask

	// List neighbors, including an isolated vertex and one out of range
	task automatic test_neighbors();
		for (int i = 0; i < 10; i++)
			send_action(ACT_NEIGHBORS, 4'(i), 4'd0, '0);
		send_action(ACT_ADD_VERTEX, 4'd0, 4'd0, $urandom());
		send_action(ACT_NEIGHBORS, 4'(vertex_total - 1), 4'd0, '0);
		send_action(ACT_NEIGHBORS, 4'd15, 4'd0, '0);
		drain_results();
	endtask

	// Write labels and read them back
	task automatic test_labels();
		logic [3:0] v;
		for (int i = 0; i < 8; i++) begin
			v = 4'($urandom_range(0, 12));
			send_action(ACT_WRITE_LABEL, v, 4'd0, $urandom());
			send_action(ACT_READ_LABEL, v, 4'd0, '0);
		end
		drain_results();
	endtask

	// Walk from every vertex and from one out of range
	task automatic test_depth_first();
		for (int i = 0; i < 11; i++)
			send_action(ACT_DFS, 4'(i), 4'd0, '0);
		send_action(ACT_DFS, 4'd14, 4'd0, '0);
		drain_results();
	endtask

	// Fill the graph, overflow it, then walk a dense graph
	task automatic test_full_graph();
		while (vertex_total < MAX_V)
			send_action(ACT_ADD_VERTEX, 4'd0, 4'd0, $urandom());
		send_action(ACT_ADD_VERTEX, 4'd0, 4'd0, $urandom());
		send_action(ACT_ADD_VERTEX, 4'd5, 4'd9, $urandom());
		for (int i = 0; i < 40; i++)
			send_action(ACT_ADD_EDGE, 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)), '0);
		for (int i = 0; i < 16; i++)
			send_action(ACT_DFS, 4'(i), 4'd0, '0);
		drain_results();
	endtask

	// Hold the receiver off while walks keep coming
	task automatic test_backpressure();
		long_hold_req = 1'b1;
		for (int i = 0; i < 24; i++)
			send_action(ACT_DFS, 4'($urandom_range(0, 15)), 4'd0, '0);
		drain_results();
	endtask

	// Random actions with idle bursts on both sides
	task automatic test_random_mix();
		for (int i = 0; i < 200; i++)
			send_random();
		drain_results();
	endtask

	// Random actions with no idling at all
	task automatic test_back_to_back();
		idle_mode = 1'b0;
		for (int i = 0; i < 64; i++)
			send_random();
		drain_results();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_mode = 1'b1;
		test_empty_graph();
		test_add_vertices();
		test_edges();
		test_neighbors();
		test_labels();
		test_depth_first();
		test_full_graph();
		test_backpressure();
		test_random_mix();
		test_back_to_back();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
